// File: design/htlm_pkg.sv
// Shared types and codes of the tree lock manager.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package htlm_pkg;

    localparam logic [1:0] CMD_LOCK    = 2'd0;
    localparam logic [1:0] CMD_UNLOCK  = 2'd1;
    localparam logic [1:0] CMD_UPGRADE = 2'd2;

    localparam logic CFG_BRANCH = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [1:0] RD_NODE   = 2'd0;
    localparam logic [1:0] RD_PARENT = 2'd1;
    localparam logic [1:0] RD_SCAN   = 2'd2;

    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_LOCK   = 3'd1;
    localparam logic [2:0] WR_UNLOCK = 3'd2;
    localparam logic [2:0] WR_INC    = 3'd3;
    localparam logic [2:0] WR_DEC    = 3'd4;
    localparam logic [2:0] WR_SWEEP  = 3'd5;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] wr_op;
        logic       lvl_init;
        logic       lvl_step;
        logic       lvl_clamp;
        logic       j_inc;
        logic       out_load;
        logic       out_ok;
    } t_ctl;

    typedef struct packed {
        logic       cfg_wr;
        logic       in_range;
        logic [1:0] cmd;
        logic       flag;
        logic       cnt_zero;
        logic       owner_eq;
        logic       node_zero;
        logic       raddr_zero;
        logic       lo_ge_cnt;
        logic       j_gt_hi;
        logic       sweep_last;
        logic       out_busy;
    } t_sts;

endpackage

`default_nettype wire

// File: design/htlm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module htlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                       i_wdata,
    input  wire                                   i_re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/htlm_ctrl.sv
// Sequencer of the tree lock manager: clearing pass, ancestor walks, subtree scans.
// Depends on htlm_pkg; drives the datapath through htlm_pkg::t_ctl.
`default_nettype none

module htlm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  htlm_pkg::t_sts   i_sts,
    output htlm_pkg::t_ctl   o_ctl
);

    localparam logic [3:0] S_SWEEP  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_FETCH  = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_AFIRST = 4'd4;
    localparam logic [3:0] S_ACHK   = 4'd5;
    localparam logic [3:0] S_LOCKRD = 4'd6;
    localparam logic [3:0] S_LOCKWR = 4'd7;
    localparam logic [3:0] S_AINC   = 4'd8;
    localparam logic [3:0] S_ADEC   = 4'd9;
    localparam logic [3:0] S_LSTEP  = 4'd10;
    localparam logic [3:0] S_LCHK   = 4'd11;
    localparam logic [3:0] S_SRD    = 4'd12;
    localparam logic [3:0] S_SCHK   = 4'd13;
    localparam logic [3:0] S_PASS   = 4'd14;
    localparam logic [3:0] S_FAIL   = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_rel, n_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_rel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rel   <= n_rel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_rel   = r_rel;
        o_ctl   = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_ctl.wr_op = htlm_pkg::WR_SWEEP;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!i_sts.in_range || !(i_sts.cmd == htlm_pkg::CMD_LOCK
                        || i_sts.cmd == htlm_pkg::CMD_UNLOCK
                        || i_sts.cmd == htlm_pkg::CMD_UPGRADE)) begin
                    n_state = S_FAIL;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_NODE;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.cmd == htlm_pkg::CMD_LOCK) begin
                    if (i_sts.flag || !i_sts.cnt_zero) begin
                        n_state = S_FAIL;
                    end else if (i_sts.node_zero) begin
                        n_state = S_LOCKRD;
                    end else begin
                        o_ctl.rd_en  = 1'b1;
                        o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                        n_state      = S_ACHK;
                    end
                end else if (i_sts.cmd == htlm_pkg::CMD_UNLOCK) begin
                    if (!i_sts.flag || !i_sts.owner_eq) begin
                        n_state = S_FAIL;
                    end else begin
                        o_ctl.wr_op = htlm_pkg::WR_UNLOCK;
                        if (i_sts.node_zero) begin
                            n_state = S_PASS;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                            n_state      = S_ADEC;
                        end
                    end
                end else begin
                    if (i_sts.flag || i_sts.cnt_zero) begin
                        n_state = S_FAIL;
                    end else begin
                        o_ctl.lvl_init = 1'b1;
                        n_rel          = 1'b0;
                        n_state        = S_LSTEP;
                    end
                end
            end
            S_AFIRST: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                n_state      = S_ACHK;
            end
            S_ACHK: begin
                if (i_sts.flag) begin
                    n_state = S_FAIL;
                end else if (i_sts.raddr_zero) begin
                    if (i_sts.cmd == htlm_pkg::CMD_LOCK) begin
                        n_state = S_LOCKRD;
                    end else begin
                        o_ctl.lvl_init = 1'b1;
                        n_rel          = 1'b1;
                        n_state        = S_LSTEP;
                    end
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                end
            end
            S_LOCKRD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_sel = htlm_pkg::RD_NODE;
                n_state      = S_LOCKWR;
            end
            S_LOCKWR: begin
                o_ctl.wr_op = htlm_pkg::WR_LOCK;
                if (i_sts.node_zero) begin
                    n_state = S_PASS;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                    n_state      = S_AINC;
                end
            end
            S_AINC: begin
                o_ctl.wr_op = htlm_pkg::WR_INC;
                if (i_sts.raddr_zero) begin
                    n_state = S_PASS;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                end
            end
            S_ADEC: begin
                o_ctl.wr_op = htlm_pkg::WR_DEC;
                if (i_sts.raddr_zero) begin
                    n_state = (i_sts.cmd == htlm_pkg::CMD_UNLOCK) ? S_PASS : S_SRD;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                end
            end
            S_LSTEP: begin
                o_ctl.lvl_step = 1'b1;
                n_state        = S_LCHK;
            end
            S_LCHK: begin
                if (!i_sts.lo_ge_cnt) begin
                    o_ctl.lvl_clamp = 1'b1;
                    n_state         = S_SRD;
                end else if (r_rel) begin
                    n_state = S_LOCKRD;
                end else if (i_sts.node_zero) begin
                    o_ctl.lvl_init = 1'b1;
                    n_rel          = 1'b1;
                    n_state        = S_LSTEP;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_NODE;
                    n_state      = S_AFIRST;
                end
            end
            S_SRD: begin
                if (i_sts.j_gt_hi) begin
                    n_state = S_LSTEP;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_SCAN;
                    n_state      = S_SCHK;
                end
            end
            S_SCHK: begin
                o_ctl.j_inc = 1'b1;
                if (!i_sts.flag) begin
                    n_state = S_SRD;
                end else if (!r_rel) begin
                    n_state = i_sts.owner_eq ? S_SRD : S_FAIL;
                end else begin
                    o_ctl.wr_op  = htlm_pkg::WR_UNLOCK;
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = htlm_pkg::RD_PARENT;
                    n_state      = S_ADEC;
                end
            end
            S_PASS: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_ok   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FAIL: begin
                if (!i_sts.out_busy) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
        if (i_sts.cfg_wr) begin
            n_state = S_SWEEP;
        end
    end

endmodule

`default_nettype wire

// File: design/htlm_dpath.sv
// Datapath of the tree lock manager: node table, level bounds, scan index, result register.
// Depends on htlm_pkg and htlm_ram.
`default_nettype none

module htlm_dpath #(
    parameter int NODES   = 1024,
    parameter int ID_BITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_valid,
    input  wire              i_cfg_index,
    input  wire [10:0]       i_cfg_data,
    input  wire [1:0]        i_cmd,
    input  wire [9:0]        i_node,
    input  wire [15:0]       i_user_id,
    input  wire              i_out_stall,
    output logic             o_out_valid,
    output logic             o_granted,
    input  htlm_pkg::t_ctl   i_ctl,
    output htlm_pkg::t_sts   o_sts
);

    localparam int AW      = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW      = AW + 5;
    localparam int EW      = (AW + 1 > 11) ? AW + 1 : 11;
    localparam int KW      = (LW > EW) ? LW : EW;
    localparam int OWN_LO  = AW;
    localparam int CNT_LO  = AW + ID_BITS;
    localparam int FLAG_B  = AW + ID_BITS + AW;
    localparam int DW      = FLAG_B + 1;

    logic [4:0]         r_branch;
    logic [10:0]        r_count;
    logic [1:0]         r_cmd;
    logic [9:0]         r_node;
    logic [ID_BITS-1:0] r_user;
    logic [AW-1:0]      r_raddr;
    logic [LW-1:0]      r_lo, r_hi, r_j;
    logic [AW-1:0]      r_sw, r_sp;
    logic [4:0]         r_sr;
    logic               r_out_valid, r_granted;

    logic [4:0]         m;
    logic [EW-1:0]      eff;
    logic [KW-1:0]      eff_k;
    logic [LW-1:0]      eff_m1;
    logic [ID_BITS+15:0] user_wide;
    logic [DW-1:0]      rdata, wdata;
    logic [AW-1:0]      raddr, waddr;
    logic               we;
    logic [AW-1:0]      rd_par, rd_cnt;
    logic [ID_BITS-1:0] rd_own;
    logic               rd_flag;
    logic               cfg_wr;

    assign cfg_wr    = i_cfg_valid;
    assign m         = (r_branch == 5'd0) ? 5'd1 : r_branch;
    assign eff       = (EW'(r_count) > EW'(NODES)) ? EW'(NODES) : EW'(r_count);
    assign eff_k     = KW'(eff);
    assign eff_m1    = LW'(eff - EW'(1));
    assign user_wide = {{ID_BITS{1'b0}}, i_user_id};

    assign rd_par  = rdata[AW-1:0];
    assign rd_own  = rdata[OWN_LO +: ID_BITS];
    assign rd_cnt  = rdata[CNT_LO +: AW];
    assign rd_flag = rdata[FLAG_B];

    always_comb begin
        case (i_ctl.rd_sel)
            htlm_pkg::RD_NODE:   raddr = AW'(r_node);
            htlm_pkg::RD_PARENT: raddr = rd_par;
            htlm_pkg::RD_SCAN:   raddr = r_j[AW-1:0];
            default:             raddr = rd_par;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_raddr;
        wdata = rdata;
        unique case (i_ctl.wr_op)
            htlm_pkg::WR_NONE:   we = 1'b0;
            htlm_pkg::WR_LOCK:   wdata = {1'b1, rd_cnt, r_user, rd_par};
            htlm_pkg::WR_UNLOCK: wdata = {1'b0, rd_cnt, {ID_BITS{1'b0}}, rd_par};
            htlm_pkg::WR_INC:    wdata = {rd_flag, rd_cnt + AW'(1), rd_own, rd_par};
            htlm_pkg::WR_DEC: begin
                wdata = {rd_flag, (rd_cnt == '0) ? rd_cnt : rd_cnt - AW'(1), rd_own, rd_par};
            end
            htlm_pkg::WR_SWEEP: begin
                waddr = r_sw;
                wdata = {1'b0, {AW{1'b0}}, {ID_BITS{1'b0}}, (r_sw == '0) ? {AW{1'b0}} : r_sp};
            end
            default:             we = 1'b0;
        endcase
    end

    htlm_ram #(
        .WIDTH (DW),
        .DEPTH (NODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch    <= 5'd2;
            r_count     <= 11'd1024;
            r_sw        <= '0;
            r_sp        <= '0;
            r_sr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (i_cfg_index == htlm_pkg::CFG_BRANCH) begin
                    r_branch <= i_cfg_data[4:0];
                end else begin
                    r_count <= i_cfg_data;
                end
                r_sw <= '0;
                r_sp <= '0;
                r_sr <= '0;
            end else if (i_ctl.wr_op == htlm_pkg::WR_SWEEP) begin
                r_sw <= r_sw + AW'(1);
                if (r_sw != '0) begin
                    if (r_sr + 5'd1 == m) begin
                        r_sr <= '0;
                        r_sp <= r_sp + AW'(1);
                    end else begin
                        r_sr <= r_sr + 5'd1;
                    end
                end
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_node <= i_node;
            r_user <= user_wide[ID_BITS-1:0];
        end
        if (i_ctl.rd_en) begin
            r_raddr <= raddr;
        end
        if (i_ctl.lvl_init) begin
            r_lo <= LW'(r_node);
            r_hi <= LW'(r_node);
        end else if (i_ctl.lvl_step) begin
            r_lo <= LW'(r_lo[AW-1:0]) * LW'(m) + LW'(1);
            r_hi <= LW'(r_hi[AW-1:0]) * LW'(m) + LW'(m);
        end else if (i_ctl.lvl_clamp) begin
            r_hi <= (r_hi > eff_m1) ? eff_m1 : r_hi;
        end
        if (i_ctl.lvl_clamp) begin
            r_j <= r_lo;
        end else if (i_ctl.j_inc) begin
            r_j <= r_j + LW'(1);
        end
        if (i_ctl.out_load) begin
            r_granted <= i_ctl.out_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;

    always_comb begin
        o_sts            = '0;
        o_sts.cfg_wr     = cfg_wr;
        o_sts.in_range   = (EW'(r_node) < eff);
        o_sts.cmd        = r_cmd;
        o_sts.flag       = rd_flag;
        o_sts.cnt_zero   = (rd_cnt == '0);
        o_sts.owner_eq   = (rd_own == r_user);
        o_sts.node_zero  = (r_node == 10'd0);
        o_sts.raddr_zero = (r_raddr == '0);
        o_sts.lo_ge_cnt  = (KW'(r_lo) >= eff_k);
        o_sts.j_gt_hi    = (r_j > r_hi);
        o_sts.sweep_last = (r_sw == AW'(NODES - 1));
        o_sts.out_busy   = r_out_valid & i_out_stall;
    end

endmodule

`default_nettype wire

// File: design/hierarchical_tree_lock_manager_unit.sv
// Tree lock manager: lock, unlock and upgrade over a breadth-first M-ary tree.
// Upgrade: a subtree pass that checks the owner of each held lock below, an ancestor walk
// (none at the root), a subtree pass that releases each lock below and walks its ancestors,
// then the lock of the node itself; the table port paces it.
// A new request is taken only once the last result is in the output register, where it waits.
// Reset and every register write start a clearing pass, during which no request is taken.
`default_nettype none

module hierarchical_tree_lock_manager_unit #(
    parameter int NODES   = 1024,
    parameter int ID_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [10:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [1:0]   i_cmd,
    input  wire [9:0]   i_node,
    input  wire [15:0]  i_user_id,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_granted
);

    htlm_pkg::t_ctl ctl;
    htlm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    htlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    htlm_dpath #(
        .NODES   (NODES),
        .ID_BITS (ID_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_node      (i_node),
        .i_user_id   (i_user_id),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_granted   (o_granted),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// File: design/htlm_checker.sv
// Port-level checks of the tree lock manager, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module htlm_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_cfg_valid,
    input wire o_cfg_ready,
    input wire i_in_valid,
    input wire o_in_stall,
    input wire o_out_valid,
    input wire i_out_stall,
    input wire o_granted
);

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a request is in progress");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after its request");

    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_in_stall)
        else $error("request taken during clearing pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_granted)))
        else $error("stalled result beat changed");

endmodule

bind hierarchical_tree_lock_manager_unit htlm_checker u_htlm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_granted   (o_granted)
);

`default_nettype wire

// File: tb/sv/hierarchical_tree_lock_manager_unit_chk.sv
// Scoreboard for the tree lock manager: follows config writes and request beats,
// predicts the grant of each request and compares it with each result beat.
// Depends on htlm_pkg for command and register codes.
`timescale 1ns / 100ps

module hierarchical_tree_lock_manager_unit_chk (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [10:0]  i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire [1:0]   i_cmd,
    input  wire [9:0]   i_node,
    input  wire [15:0]  i_user_id,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire         i_granted,
    output int          o_fails,
    output int          o_pending
);

    localparam int TREE_SIZE = 1024;

    logic        held[TREE_SIZE];
    logic [15:0] holder[TREE_SIZE];
    int unsigned held_below[TREE_SIZE];
    logic [4:0]  fanout_reg;
    logic [10:0] count_reg;
    bit          grant_q[$];
    int          fails;

    assign o_fails = fails;

    function automatic int unsigned fanout();
        return (fanout_reg == 0) ? 1 : fanout_reg;
    endfunction

    function automatic int unsigned used_nodes();
        return (count_reg > TREE_SIZE) ? TREE_SIZE : count_reg;
    endfunction

    function automatic void release_all();
        for (int i = 0; i < TREE_SIZE; i++) begin
            held[i]       = 1'b0;
            holder[i]     = '0;
            held_below[i] = 0;
        end
    endfunction

    function automatic void bump_ancestors(int unsigned j, bit up);
        int unsigned m;
        m = fanout();
        while (j > 0) begin
            j = (j - 1) / m;
            if (up)
                held_below[j]++;
            else if (held_below[j] > 0)
                held_below[j]--;
        end
    endfunction

    function automatic bit ancestor_held(int unsigned j);
        int unsigned m;
        m = fanout();
        while (j > 0) begin
            j = (j - 1) / m;
            if (held[j])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_lock(int unsigned n, logic [15:0] u);
        if (held[n] || held_below[n] != 0 || ancestor_held(n))
            return 1'b0;
        held[n]   = 1'b1;
        holder[n] = u;
        bump_ancestors(n, 1'b1);
        return 1'b1;
    endfunction

    function automatic bit drop_lock(int unsigned n, logic [15:0] u);
        if (!held[n] || holder[n] != u)
            return 1'b0;
        bump_ancestors(n, 1'b0);
        held[n]   = 1'b0;
        holder[n] = '0;
        return 1'b1;
    endfunction

    function automatic bit sweep_subtree(int unsigned n, logic [15:0] u, bit rel);
        longint unsigned m, cnt, lo, hi;
        bit dummy;
        m   = fanout();
        cnt = used_nodes();
        lo  = n;
        hi  = n;
        forever begin
            lo = lo * m + 1;
            hi = hi * m + m;
            if (lo >= cnt)
                break;
            if (hi >= cnt)
                hi = cnt - 1;
            for (longint unsigned j = lo; j <= hi; j++) begin
                if (!held[j])
                    continue;
                if (rel)
                    dummy = drop_lock(32'(j), u);
                else if (holder[j] != u)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit upgrade_lock(int unsigned n, logic [15:0] u);
        bit dummy;
        if (held[n] || held_below[n] == 0)
            return 1'b0;
        if (!sweep_subtree(n, u, 1'b0))
            return 1'b0;
        if (ancestor_held(n))
            return 1'b0;
        dummy = sweep_subtree(n, u, 1'b1);
        return take_lock(n, u);
    endfunction

    function automatic bit predict_grant(logic [1:0] c, int unsigned n, logic [15:0] u);
        if (n >= used_nodes())
            return 1'b0;
        case (c)
            htlm_pkg::CMD_LOCK:    return take_lock(n, u);
            htlm_pkg::CMD_UNLOCK:  return drop_lock(n, u);
            htlm_pkg::CMD_UPGRADE: return upgrade_lock(n, u);
            default:               return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            release_all();
            fanout_reg = 5'd2;
            count_reg  = 11'd1024;
            grant_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == htlm_pkg::CFG_BRANCH)
                    fanout_reg = i_cfg_data[4:0];
                else
                    count_reg = i_cfg_data;
                release_all();
            end
            if (i_out_valid && !i_out_stall) begin
                if (grant_q.size() == 0) begin
                    $error("granted: no request waiting, got %0d", i_granted);
                    fails++;
                end else begin
                    want = grant_q.pop_front();
                    if (i_granted !== want) begin
                        $error("granted: expected %0d, got %0d", want, i_granted);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                grant_q.insert(grant_q.size(), predict_grant(i_cmd, i_node, i_user_id));
        end
        o_pending = grant_q.size();
    end

endmodule

// File: tb/sv/hierarchical_tree_lock_manager_unit_tb.sv
// Top of the tree lock manager testbench: clock, reset, request and config stimulus,
// result back-pressure, watchdog and verdict.
// Depends on htlm_pkg, the block and hierarchical_tree_lock_manager_unit_chk.
`timescale 1ns / 100ps

module hierarchical_tree_lock_manager_unit_tb;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  cmd = '0;
    logic [9:0]  node = '0;
    logic [15:0] user_id = '0;
    logic        out_stall = 1'b0;
    wire         cfg_ready, in_stall, out_valid, granted;
    int          fails, pending;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    int unsigned span = 1024;
    logic [15:0] users[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5};

    always #5 clk = ~clk;

    hierarchical_tree_lock_manager_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_cmd(cmd), .i_node(node), .i_user_id(user_id),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_granted(granted)
    );

    hierarchical_tree_lock_manager_unit_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_cmd(cmd), .i_node(node), .i_user_id(user_id),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_granted(granted),
        .o_fails(fails), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && !in_stall)
                || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned w;
        @(posedge rst_n);
        forever begin
            w = quiet ? 0 : $urandom_range(0, 18);
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send(logic [1:0] c, logic [9:0] n, logic [15:0] u);
        int unsigned w;
        w = quiet ? 0 : $urandom_range(0, 18);
        if (w > 0) begin
            in_valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        cmd      <= c;
        node     <= n;
        user_id  <= u;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup(logic [4:0] m, logic [10:0] cnt);
        write_reg(htlm_pkg::CFG_BRANCH, {6'd0, m});
        write_reg(htlm_pkg::CFG_COUNT, cnt);
        span = (cnt > 1024) ? 1024 : cnt;
    endtask

    task automatic random_items(int num);
        logic [1:0]  c;
        logic [9:0]  n;
        logic [15:0] u;
        int unsigned r, reach;
        reach = (span == 0) ? 0 : ((span > 31) ? 30 : span - 1);
        for (int i = 0; i < num; i++) begin
            r = $urandom_range(0, 99);
            c = (r < 40) ? htlm_pkg::CMD_LOCK : (r < 65) ? htlm_pkg::CMD_UNLOCK
              : (r < 95) ? htlm_pkg::CMD_UPGRADE : CMD_SPARE;
            n = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(0, reach));
            u = ($urandom_range(0, 11) == 0) ? 16'($urandom)
                                              : users[$urandom_range(0, 3)];
            send(c, n, u);
            if (i == num / 2 && $urandom_range(0, 1))
                drain();
        end
        drain();
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(htlm_pkg::CMD_LOCK, 10'd0, 16'h0001);
        send(htlm_pkg::CMD_LOCK, 10'd1, 16'h0001);
        send(htlm_pkg::CMD_UNLOCK, 10'd0, 16'h0002);
        send(htlm_pkg::CMD_UNLOCK, 10'd0, 16'h0001);
        send(htlm_pkg::CMD_LOCK, 10'd3, 16'hFFFF);
        send(htlm_pkg::CMD_LOCK, 10'd4, 16'hFFFF);
        send(htlm_pkg::CMD_UPGRADE, 10'd1, 16'hFFFF);
        send(htlm_pkg::CMD_LOCK, 10'd1023, 16'h0000);
        send(htlm_pkg::CMD_UPGRADE, 10'd0, 16'h0000);
        send(CMD_SPARE, 10'd0, 16'h0000);
        send(htlm_pkg::CMD_UNLOCK, 10'd1023, 16'h0000);
        send(htlm_pkg::CMD_UNLOCK, 10'd1, 16'hFFFF);
        send(htlm_pkg::CMD_UPGRADE, 10'd0, 16'hFFFF);
        send(htlm_pkg::CMD_LOCK, 10'd2, 16'h5A5A);
        send(htlm_pkg::CMD_UPGRADE, 10'd0, 16'h5A5A);
        send(htlm_pkg::CMD_UNLOCK, 10'd0, 16'h5A5A);
        drain();
        setup(5'd2, 11'd5);
        send(htlm_pkg::CMD_LOCK, 10'd5, 16'h0001);
        send(htlm_pkg::CMD_LOCK, 10'd4, 16'h0001);
        send(htlm_pkg::CMD_UPGRADE, 10'd1023, 16'h0001);
        drain();

        quiet = 1'b1;
        setup(5'd3, 11'd40);     random_items(110);
        quiet = 1'b0;
        setup(5'd1, 11'd20);     random_items(110);
        setup(5'd16, 11'd300);   random_items(110);
        setup(5'd31, 11'd2047);  random_items(100);
        setup(5'd0, 11'd0);      random_items(20);
        setup(5'd2, 11'd1024);   random_items(200);
        setup(5'd4, 11'd1);      random_items(40);
        quiet = 1'b1;
        setup(5'd5, 11'd100);    random_items(80);
        quiet = 1'b0;
        setup(5'd2, 11'd63);     random_items(110);

        drain();
        repeat (20) @(negedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
